// ----- sv/gai_pkg.sv -----
// ----------------------------------------------------------------------------
// gai_pkg
// shared widths, constants, types and helpers of the gyro angle integrator
// ----------------------------------------------------------------------------
package gai_pkg;

   // fixed field widths
   localparam int SAMPLE_W = 16;
   localparam int ANGLE_W  = 17;
   localparam int SUM_W    = 24;
   localparam int RATE_W   = 11;
   localparam int PHASE_W  = 9;

   // lanes in the word, parameter defaults
   localparam int NUM_LANES       = 3;
   localparam int CAL_SAMPLES_DEF = 200;
   localparam int AXES_DEF        = 3;

   // heading wraps at 360 degrees in 1/200 degree units
   localparam int FULL_TURN = 72000;

   // divide by 100 via reciprocal: exact for inputs below 2**17
   localparam int RATE_DIV    = 100;
   localparam int RECIP_SHIFT = 24;
   localparam logic [17:0] RECIP100 = 18'(((2 ** RECIP_SHIFT) + RATE_DIV - 1) / RATE_DIV);

   // per-axis state entry held in the state memory
   typedef struct packed {
      logic signed [SUM_W-1:0]    bias_sum;
      logic signed [SAMPLE_W-1:0] axis_bias;
      logic [SAMPLE_W-1:0]        noise_level;
      logic signed [RATE_W-1:0]   last_rate;
      logic [ANGLE_W-1:0]         heading;
   } gai_entry_type;

   localparam int ENTRY_W = $bits(gai_entry_type);

   // calibration phase of one word
   typedef struct packed {
      logic in_bias;
      logic last_bias;
      logic in_noise;
      logic last_noise;
      logic cal;
   } gai_flags_type;

   // result word
   typedef struct packed {
      logic [ANGLE_W-1:0] angle_x;
      logic [ANGLE_W-1:0] angle_y;
      logic [ANGLE_W-1:0] angle_z;
      logic               calibrating;
   } gai_rsp_word_type;

   // unsigned magnitude divided by 100, truncated
   function automatic logic [RATE_W-1:0] div100(input logic [ANGLE_W-1:0] mag);
      logic [34:0] prod;
      prod = 35'(mag) * 35'(RECIP100);
      return prod[RECIP_SHIFT+RATE_W-1:RECIP_SHIFT];
   endfunction

endpackage

// ----- sv/gai_req_if.sv -----
// ----------------------------------------------------------------------------
// gai_req_if
// sample channel: valid/ready with one x/y/z gyro word
// ----------------------------------------------------------------------------
interface gai_req_if;
   import gai_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] gyro_x;
   logic signed [SAMPLE_W-1:0] gyro_y;
   logic signed [SAMPLE_W-1:0] gyro_z;

   modport source (output valid, output gyro_x, output gyro_y, output gyro_z, input ready);
   modport sink   (input valid, input gyro_x, input gyro_y, input gyro_z, output ready);
endinterface

// ----- sv/gai_rsp_if.sv -----
// ----------------------------------------------------------------------------
// gai_rsp_if
// result channel: valid/ready with one heading word
// ----------------------------------------------------------------------------
interface gai_rsp_if;
   import gai_pkg::*;

   logic               valid;
   logic               ready;
   logic [ANGLE_W-1:0] angle_x;
   logic [ANGLE_W-1:0] angle_y;
   logic [ANGLE_W-1:0] angle_z;
   logic               calibrating;

   modport source (output valid, output angle_x, output angle_y, output angle_z,
                   output calibrating, input ready);
   modport sink   (input valid, input angle_x, input angle_y, input angle_z,
                   input calibrating, output ready);
endinterface

// ----- sv/gyro_angle_integrator_top.sv -----
// ----------------------------------------------------------------------------
// gyro_angle_integrator_top
// gyro bias/noise calibration and trapezoid rate integration per axis
// ----------------------------------------------------------------------------
// The first CAL_SAMPLES words set each axis bias, the next CAL_SAMPLES set
// the deadband, and later words integrate (sample - bias) / 100 into a heading
// in 1/200 degree units, wrapped into 0..71999. All per-axis state sits in one
// small ram, one entry per axis, and each axis is a read-modify-write through
// its read and write ports. The axes of a word are read in turn; a new word
// is accepted once all reads of the last word are issued and fewer than two
// words are outstanding. Each word's result goes into a two-word output queue
// from the last axis's modify stage, ready to leave next cycle. Entry valid
// bits stand in for clearing the ram, so the block is ready right after reset.
// ----------------------------------------------------------------------------
module gyro_angle_integrator_top #(
   parameter int CAL_SAMPLES = gai_pkg::CAL_SAMPLES_DEF,
   parameter int AXES        = gai_pkg::AXES_DEF
) (
   input logic       clock,
   input logic       reset,
   gai_req_if.sink   req_chan,
   gai_rsp_if.source rsp_chan
);
   import gai_pkg::*;

   localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;
   localparam logic [32:0] BIAS_RECIP =
      33'(((64'd1 << 32) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
   localparam logic [PHASE_W-1:0] BIAS_END  = PHASE_W'(CAL_SAMPLES);
   localparam logic [PHASE_W-1:0] NOISE_END = PHASE_W'(2 * CAL_SAMPLES);
   localparam logic [AXIS_W-1:0]  LAST_AXIS = AXIS_W'(AXES - 1);

   // handshake and phase
   logic                       accept;
   logic                       take;
   logic [PHASE_W-1:0]         phase_ff, phase_in;
   gai_flags_type              acc_flags;
   gai_flags_type              item_flags_ff;
   logic signed [SAMPLE_W-1:0] req_s [NUM_LANES];
   logic signed [SAMPLE_W-1:0] sample_ff [NUM_LANES];

   // read sequencer
   logic                       rd_busy_ff, rd_busy_in;
   logic [AXIS_W-1:0]          rd_axis_ff, rd_axis_in;
   logic                       rd_issue;
   logic [AXIS_W-1:0]          rd_addr;
   gai_flags_type              rd_flags;
   logic signed [SAMPLE_W-1:0] rd_sample;
   logic                       rd_last;

   // modify stage
   logic                       b_valid_ff;
   logic [AXIS_W-1:0]          b_axis_ff;
   logic                       b_last_ff;
   gai_flags_type              b_flags_ff;
   logic signed [SAMPLE_W-1:0] b_sample_ff;
   logic                       b_entry_ok_ff;
   logic                       fwd_hit_ff;
   gai_entry_type              fwd_data_ff;
   logic [AXES-1:0]            ent_valid_ff;
   logic [ENTRY_W-1:0]         ram_rdata;
   gai_entry_type              entry_cur;
   gai_entry_type              entry_new;
   logic [ANGLE_W-1:0]         hold_ff [NUM_LANES];

   // output queue
   logic                       push;
   gai_rsp_word_type           push_word;
   gai_rsp_word_type           fifo_ff [2];
   logic                       wr_ptr_ff, rd_ptr_ff;
   logic [1:0]                 cnt_ff;
   logic [1:0]                 occ_ff;
   gai_rsp_word_type           out_word;

   assign req_s[0] = req_chan.gyro_x;
   assign req_s[1] = req_chan.gyro_y;
   assign req_s[2] = req_chan.gyro_z;

   // room for one more word in flight or queued
   assign take            = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready  = !rd_busy_ff && ((occ_ff < 2'd2) || take);
   assign accept          = req_chan.valid && req_chan.ready;

   // phase of the word being accepted
   always_comb begin
      acc_flags.in_bias    = phase_ff < BIAS_END;
      acc_flags.last_bias  = phase_ff == BIAS_END - PHASE_W'(1);
      acc_flags.cal        = phase_ff < NOISE_END;
      acc_flags.in_noise   = !acc_flags.in_bias && acc_flags.cal;
      acc_flags.last_noise = phase_ff == NOISE_END - PHASE_W'(1);
      phase_in             = phase_ff;
      if (accept && acc_flags.cal) begin
         phase_in = phase_ff + PHASE_W'(1);
      end
   end

   // read issue: axis 0 on accept, then one axis per cycle
   always_comb begin
      rd_issue   = accept || rd_busy_ff;
      rd_addr    = rd_busy_ff ? rd_axis_ff : '0;
      rd_flags   = rd_busy_ff ? item_flags_ff : acc_flags;
      rd_sample  = rd_busy_ff ? sample_ff[rd_axis_ff] : req_s[0];
      rd_last    = rd_addr == LAST_AXIS;
      rd_busy_in = rd_busy_ff;
      rd_axis_in = rd_axis_ff;
      if (accept) begin
         rd_busy_in = AXES > 1;
         rd_axis_in = AXIS_W'(1);
      end else if (rd_busy_ff) begin
         if (rd_last) begin
            rd_busy_in = 1'b0;
         end else begin
            rd_axis_in = rd_axis_ff + AXIS_W'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         rd_busy_ff   <= 1'b0;
         rd_axis_ff   <= '0;
         b_valid_ff   <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         ent_valid_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         rd_busy_ff <= rd_busy_in;
         rd_axis_ff <= rd_axis_in;
         b_valid_ff <= rd_issue;
         fwd_hit_ff <= b_valid_ff && rd_issue && (b_axis_ff == rd_addr);
         if (b_valid_ff) begin
            ent_valid_ff[b_axis_ff] <= 1'b1;
         end
      end
   end

   // word and stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         item_flags_ff <= acc_flags;
         for (int i = 0; i < NUM_LANES; i++) begin
            sample_ff[i] <= req_s[i];
         end
      end
      if (rd_issue) begin
         b_axis_ff     <= rd_addr;
         b_last_ff     <= rd_last;
         b_flags_ff    <= rd_flags;
         b_sample_ff   <= rd_sample;
         b_entry_ok_ff <= ent_valid_ff[rd_addr];
      end
      fwd_data_ff <= entry_new;
      if (b_valid_ff) begin
         hold_ff[b_axis_ff] <= entry_new.heading;
      end
   end

   // per-axis state memory
   gai_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (AXES)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_axis_ff),
      .wr_data (entry_new),
      .rd_en   (rd_issue),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // entry seen by the modify stage: forwarded, stored or reset value
   always_comb begin
      if (fwd_hit_ff) begin
         entry_cur = fwd_data_ff;
      end else if (b_entry_ok_ff) begin
         entry_cur = gai_entry_type'(ram_rdata);
      end else begin
         entry_cur = '0;
      end
   end

   // modify: bias sum, noise peak or integration
   always_comb begin
      logic signed [SUM_W-1:0]    sum_new;
      logic [SUM_W-1:0]           sum_mag;
      logic [56:0]                bias_prod;
      logic [SAMPLE_W-1:0]        bias_q;
      logic signed [ANGLE_W-1:0]  diff;
      logic [ANGLE_W-1:0]         mag;
      logic [SAMPLE_W-1:0]        peak;
      logic [RATE_W-1:0]          peak_div;
      logic [RATE_W-1:0]          rate_mag;
      logic signed [RATE_W-1:0]   rate;
      logic signed [ANGLE_W-1:0]  rate_x;
      logic signed [ANGLE_W-1:0]  dead;
      logic signed [RATE_W:0]     step;
      logic signed [ANGLE_W:0]    hsum;
      logic                       clear;

      entry_new = entry_cur;

      sum_new   = entry_cur.bias_sum + SUM_W'(b_sample_ff);
      sum_mag   = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
      bias_prod = 57'(sum_mag) * 57'(BIAS_RECIP);
      bias_q    = bias_prod[32+SAMPLE_W-1:32];

      diff     = ANGLE_W'(b_sample_ff) - ANGLE_W'(entry_cur.axis_bias);
      mag      = diff[ANGLE_W-1] ? ANGLE_W'(-diff) : ANGLE_W'(diff);
      peak     = (mag[SAMPLE_W-1:0] > entry_cur.noise_level) ? mag[SAMPLE_W-1:0]
                                                             : entry_cur.noise_level;
      peak_div = div100({1'b0, peak});

      rate_mag = div100(mag);
      rate     = diff[ANGLE_W-1] ? -$signed(rate_mag) : $signed(rate_mag);
      rate_x   = ANGLE_W'(rate);
      dead     = $signed({1'b0, entry_cur.noise_level});
      clear    = (rate_x >= dead) || (rate_x <= -dead);
      step     = (RATE_W+1)'(entry_cur.last_rate) + (RATE_W+1)'(rate);
      hsum     = $signed({1'b0, entry_cur.heading});
      if (clear) begin
         hsum = hsum + (ANGLE_W+1)'(step);
      end
      if (hsum >= (ANGLE_W+1)'(FULL_TURN)) begin
         hsum = hsum - (ANGLE_W+1)'(FULL_TURN);
      end else if (hsum < 0) begin
         hsum = hsum + (ANGLE_W+1)'(FULL_TURN);
      end

      if (b_flags_ff.in_bias) begin
         entry_new.bias_sum = sum_new;
         if (b_flags_ff.last_bias) begin
            entry_new.axis_bias = sum_new[SUM_W-1] ? -$signed(bias_q) : $signed(bias_q);
         end
      end else if (b_flags_ff.in_noise) begin
         entry_new.noise_level = b_flags_ff.last_noise ? SAMPLE_W'(peak_div) : peak;
      end else begin
         entry_new.last_rate = rate;
         entry_new.heading   = hsum[ANGLE_W-1:0];
      end
   end

   // result word on the last axis
   always_comb begin
      logic [ANGLE_W-1:0] ang [NUM_LANES];
      for (int i = 0; i < NUM_LANES; i++) begin
         ang[i] = '0;
         if (i < AXES) begin
            ang[i] = (AXIS_W'(i) == b_axis_ff) ? entry_new.heading : hold_ff[i];
         end
      end
      push                  = b_valid_ff && b_last_ff;
      push_word.angle_x     = ang[0];
      push_word.angle_y     = ang[1];
      push_word.angle_z     = ang[2];
      push_word.calibrating = b_flags_ff.cal;
   end

   // two-word output queue and outstanding count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
         occ_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (take) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(take);
         occ_ff <= occ_ff + 2'(accept) - 2'(take);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign out_word             = fifo_ff[rd_ptr_ff];
   assign rsp_chan.valid       = cnt_ff != 2'd0;
   assign rsp_chan.angle_x     = out_word.angle_x;
   assign rsp_chan.angle_y     = out_word.angle_y;
   assign rsp_chan.angle_z     = out_word.angle_z;
   assign rsp_chan.calibrating = out_word.calibrating;

   // checks
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && (cnt_ff == 2'd2) && !take))
      else $error("output queue overflow");

   a_queue_in_occ: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= occ_ff)
      else $error("queued words exceed outstanding words");

   a_seq_start: assert property (@(posedge clock) disable iff (reset)
      (accept && (AXES > 1)) |=> rd_busy_ff)
      else $error("axis sequencer did not start");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (entry_new.heading < ANGLE_W'(FULL_TURN)))
      else $error("heading out of range");

endmodule

// ----- sv/gai_ram.sv -----
// ----------------------------------------------------------------------------
// gai_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module gai_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
